/* rtl/jet_pkg.sv */
// shared constants, types and helpers of the julia escape-time pixel block
// no dependencies; every other file imports this package
package jet_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 16;

    localparam int WORD_W     = 32;
    localparam int ACC_W      = 2 * WORD_W;
    localparam int SIZE_W     = COORD_BITS + 1;
    localparam int QUO_W      = COORD_BITS + FRAC_BITS;
    localparam int LO_W       = (QUO_W + 1) / 2;
    localparam int HI_W       = QUO_W - LO_W;
    localparam int ZOOM_W     = 16;
    localparam int ZOOM_FRAC  = 12;
    localparam int SHIFT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

    localparam logic signed [ACC_W-1:0] WORD_MAX  = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] WORD_MIN  = -64'sd2147483648;
    localparam logic signed [ACC_W-1:0] CLAMP_RAW = 64'sd100 <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SQ_CLAMP  = (CLAMP_RAW > WORD_MAX) ? WORD_MAX : CLAMP_RAW;
    localparam logic signed [ACC_W-1:0] ESC_LIMIT = 64'sd4 <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF_FIX  = 64'sd1 <<< (FRAC_BITS - 1);

    localparam logic signed [WORD_W-1:0]  C_REAL_RST   = -32'sd12247367;
    localparam logic signed [WORD_W-1:0]  C_IMAG_RST   = 32'sd3187671;
    localparam logic [COUNT_BITS-1:0]     MAX_ITER_RST = 16'd200;
    localparam logic [SIZE_W-1:0]         WIDTH_RST    = 13'd400;
    localparam logic [SIZE_W-1:0]         HEIGHT_RST   = 13'd400;
    localparam logic signed [ZOOM_W-1:0]  ZOOM_RST     = 16'sd4096;
    localparam logic signed [SHIFT_W-1:0] SHIFT_RST    = 8'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL       = 3'd0,
        CFG_C_IMAG       = 3'd1,
        CFG_MAX_ITER     = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4,
        CFG_ZOOM         = 3'd5,
        CFG_SHIFT_REAL   = 3'd6,
        CFG_SHIFT_IMAG   = 3'd7
    } t_cfg_idx;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DIV_X    = 8'b0000_0010,
        ST_MAP_X    = 8'b0000_0100,
        ST_DIV_Y    = 8'b0000_1000,
        ST_MAP_Y    = 8'b0001_0000,
        ST_ITER_MUL = 8'b0010_0000,
        ST_ITER_UPD = 8'b0100_0000,
        ST_FIN      = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] pos;
        logic [SIZE_W-1:0]     size;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic signed [WORD_W-1:0] a0, b0, a1, b1, a2, b2;
    } t_mul_ops;

    typedef struct packed {
        logic signed [ACC_W-1:0] p0, p1, p2;
    } t_mul_prods;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        if (v > WORD_MAX) begin
            s = WORD_MAX;
        end else if (v < WORD_MIN) begin
            s = WORD_MIN;
        end else begin
            s = v;
        end
        return s[WORD_W-1:0];
    endfunction

endpackage

/* rtl/jet_pix_if.sv */
// pixel input channel: valid/ready handshake with column and row
// depends on jet_pkg
interface jet_pix_if import jet_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_column;
    logic [COORD_BITS-1:0] pixel_row;

    modport source (output valid, output pixel_column, output pixel_row, input ready);
    modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

/* rtl/jet_res_if.sv */
// result channel: valid/ready handshake with pixel position, count and escape flag
// depends on jet_pkg
interface jet_res_if import jet_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_column;
    logic [COORD_BITS-1:0] out_row;
    logic [COUNT_BITS-1:0] iteration_count;
    logic                  escaped;

    modport source (output valid, output out_column, output out_row,
                    output iteration_count, output escaped, input ready);
    modport sink   (input valid, input out_column, input out_row,
                    input iteration_count, input escaped, output ready);
endinterface

/* rtl/jet_div.sv */
// restoring divider, one quotient bit per cycle: (pos << FRAC_BITS) / size
// depends on jet_pkg
module jet_div import jet_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0]     r_quo;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    r_div;

    logic [SIZE_W:0]      rem_sh;
    logic [SIZE_W:0]      rem_dif;
    logic                 ge;
    logic [SIZE_W-1:0]    n_rem;
    logic [QUO_W-1:0]     n_quo;

    always_comb begin
        rem_sh  = {r_rem, r_quo[QUO_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_dif = rem_sh - {1'b0, r_div};
        n_rem   = ge ? rem_dif[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
        n_quo   = {r_quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= {i_req.pos, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_div <= i_req.size;
            r_cnt <= DIV_CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

/* rtl/jet_mul.sv */
// three signed 32x32 multipliers with registered 64-bit products
// depends on jet_pkg
module jet_mul import jet_pkg::*; (
    input  logic       i_clk,
    input  t_mul_ops   i_ops,
    output t_mul_prods o_prods
);
    t_mul_prods r_prods;

    always_ff @(posedge i_clk) begin
        r_prods.p0 <= i_ops.a0 * i_ops.b0;
        r_prods.p1 <= i_ops.a1 * i_ops.b1;
        r_prods.p2 <= i_ops.a2 * i_ops.b2;
    end

    assign o_prods = r_prods;

endmodule

/* rtl/julia_escape_time_pixel.sv */
// julia escape-time pixel unit: sequencer, configuration registers and result register
// depends on jet_pkg, jet_pix_if, jet_res_if, jet_div, jet_mul
//
// usage:
//   i_pix carries one pixel (column, row) per beat, o_res returns one beat per
//   pixel with the position, the iteration count and the escaped flag.
//   configuration is written through i_cfg_we / i_cfg_index / i_cfg_data, by
//   the user only while the block has nothing in flight; the block does not enforce it.
// sequence:
//   the start point of each axis goes through the serial divider (one quotient
//   bit per cycle) and the scaling multipliers. every iteration then passes
//   through the shared complex-square unit in a multiply step, then an update
//   step. one pixel is in work at a time; i_pix.ready is high only while the
//   sequencer is idle.
// reset and stall:
//   reset returns the sequencer to idle, empties the result register and loads
//   the default configuration. a finished result waits in the result register;
//   the next pixel is accepted meanwhile, and a second result waits in the
//   sequencer until the first beat is taken.
module julia_escape_time_pixel import jet_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jet_pix_if.sink               i_pix,
    jet_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    // configuration
    logic signed [WORD_W-1:0]  r_c_re;
    logic signed [WORD_W-1:0]  r_c_im;
    logic [COUNT_BITS-1:0]     r_max_iter;
    logic [SIZE_W-1:0]         r_width;
    logic [SIZE_W-1:0]         r_height;
    logic signed [ZOOM_W-1:0]  r_zoom;
    logic signed [SHIFT_W-1:0] r_shift_re;
    logic signed [SHIFT_W-1:0] r_shift_im;

    // sequencer and working registers
    t_state                    r_state, n_state;
    logic [COORD_BITS-1:0]     r_col, n_col;
    logic [COORD_BITS-1:0]     r_row, n_row;
    logic signed [WORD_W-1:0]  r_zx, n_zx;
    logic signed [WORD_W-1:0]  r_zy, n_zy;
    logic [COUNT_BITS-1:0]     r_cnt, n_cnt;
    logic                      r_esc, n_esc;

    // result register
    logic                      r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]     r_out_col, n_out_col;
    logic [COORD_BITS-1:0]     r_out_row, n_out_row;
    logic [COUNT_BITS-1:0]     r_out_cnt, n_out_cnt;
    logic                      r_out_esc, n_out_esc;

    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    t_mul_ops                  mul_ops;
    t_mul_prods                prods;

    logic [SIZE_W-1:0]         width_eff;
    logic [SIZE_W-1:0]         height_eff;
    logic signed [ACC_W-1:0]   scaled;
    logic signed [ACC_W-1:0]   t_val;
    logic signed [ACC_W-1:0]   shift_ext;
    logic signed [ACC_W-1:0]   z_raw;
    logic signed [WORD_W-1:0]  z_map;
    logic signed [ACC_W-1:0]   x2_full, y2_full, xy_full;
    logic signed [ACC_W-1:0]   x2, y2;
    logic signed [ACC_W-1:0]   c_re_ext, c_im_ext;
    logic signed [WORD_W-1:0]  zx_next, zy_next;
    logic                      esc_hit;
    logic [COUNT_BITS-1:0]     cnt_inc;
    logic                      div_phase;

    jet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    jet_mul u_mul (
        .i_clk   (i_clk),
        .i_ops   (mul_ops),
        .o_prods (prods)
    );

    assign width_eff  = (r_width  == '0) ? SIZE_W'(1) : r_width;
    assign height_eff = (r_height == '0) ? SIZE_W'(1) : r_height;
    assign div_phase  = (r_state == ST_DIV_X) || (r_state == ST_DIV_Y);

    // operand select: quotient halves times zoom, or the complex square
    always_comb begin
        if (div_phase) begin
            mul_ops.a0 = {{(WORD_W-LO_W){1'b0}}, div_rsp.quo[LO_W-1:0]};
            mul_ops.b0 = {{(WORD_W-ZOOM_W){r_zoom[ZOOM_W-1]}}, r_zoom};
            mul_ops.a1 = {{(WORD_W-HI_W){1'b0}}, div_rsp.quo[QUO_W-1:LO_W]};
            mul_ops.b1 = {{(WORD_W-ZOOM_W){r_zoom[ZOOM_W-1]}}, r_zoom};
            mul_ops.a2 = '0;
            mul_ops.b2 = '0;
        end else begin
            mul_ops.a0 = r_zx;
            mul_ops.b0 = r_zx;
            mul_ops.a1 = r_zy;
            mul_ops.b1 = r_zy;
            mul_ops.a2 = r_zx;
            mul_ops.b2 = r_zy;
        end
    end

    // start point from the scaled quotient
    always_comb begin
        if (r_state == ST_MAP_X) begin
            shift_ext = {{(ACC_W-SHIFT_W){r_shift_re[SHIFT_W-1]}}, r_shift_re};
        end else begin
            shift_ext = {{(ACC_W-SHIFT_W){r_shift_im[SHIFT_W-1]}}, r_shift_im};
        end
        scaled = (prods.p1 <<< LO_W) + prods.p0;
        t_val  = (scaled >>> ZOOM_FRAC) - HALF_FIX;
        z_raw  = (t_val <<< 1) + t_val + (shift_ext <<< FRAC_BITS);
        z_map  = sat32(z_raw);
    end

    // one iteration step from the registered products
    always_comb begin
        c_re_ext = {{(ACC_W-WORD_W){r_c_re[WORD_W-1]}}, r_c_re};
        c_im_ext = {{(ACC_W-WORD_W){r_c_im[WORD_W-1]}}, r_c_im};
        x2_full  = prods.p0 >>> FRAC_BITS;
        y2_full  = prods.p1 >>> FRAC_BITS;
        xy_full  = prods.p2 >>> FRAC_BITS;
        x2       = (x2_full > SQ_CLAMP) ? SQ_CLAMP : x2_full;
        y2       = (y2_full > SQ_CLAMP) ? SQ_CLAMP : y2_full;
        zy_next  = sat32((xy_full <<< 1) + c_im_ext);
        zx_next  = sat32(x2 - y2 + c_re_ext);
        esc_hit  = (x2 + y2) > ESC_LIMIT;
        cnt_inc  = r_cnt + COUNT_BITS'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_zx        = r_zx;
        n_zy        = r_zy;
        n_cnt       = r_cnt;
        n_esc       = r_esc;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_cnt   = r_out_cnt;
        n_out_esc   = r_out_esc;
        div_req     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pix.valid) begin
                    n_col         = i_pix.pixel_column;
                    n_row         = i_pix.pixel_row;
                    div_req.start = 1'b1;
                    div_req.pos   = i_pix.pixel_column;
                    div_req.size  = width_eff;
                    n_state       = ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (div_rsp.done) begin
                    n_state = ST_MAP_X;
                end
            end
            ST_MAP_X: begin
                n_zx          = z_map;
                div_req.start = 1'b1;
                div_req.pos   = r_row;
                div_req.size  = height_eff;
                n_state       = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                if (div_rsp.done) begin
                    n_state = ST_MAP_Y;
                end
            end
            ST_MAP_Y: begin
                n_zy  = z_map;
                n_cnt = '0;
                if (r_max_iter == '0) begin
                    n_esc   = 1'b0;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_ITER_MUL;
                end
            end
            ST_ITER_MUL: begin
                n_state = ST_ITER_UPD;
            end
            ST_ITER_UPD: begin
                n_zx = zx_next;
                n_zy = zy_next;
                if (esc_hit) begin
                    n_esc   = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    n_cnt = cnt_inc;
                    if (cnt_inc == r_max_iter) begin
                        n_esc   = 1'b0;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_ITER_MUL;
                    end
                end
            end
            ST_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_col   = r_col;
                    n_out_row   = r_row;
                    n_out_cnt   = r_cnt;
                    n_out_esc   = r_esc;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col     <= n_col;
        r_row     <= n_row;
        r_zx      <= n_zx;
        r_zy      <= n_zy;
        r_cnt     <= n_cnt;
        r_esc     <= n_esc;
        r_out_col <= n_out_col;
        r_out_row <= n_out_row;
        r_out_cnt <= n_out_cnt;
        r_out_esc <= n_out_esc;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_re     <= C_REAL_RST;
            r_c_im     <= C_IMAG_RST;
            r_max_iter <= MAX_ITER_RST;
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
            r_zoom     <= ZOOM_RST;
            r_shift_re <= SHIFT_RST;
            r_shift_im <= SHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_C_REAL:       r_c_re     <= i_cfg_data[WORD_W-1:0];
                CFG_C_IMAG:       r_c_im     <= i_cfg_data[WORD_W-1:0];
                CFG_MAX_ITER:     r_max_iter <= i_cfg_data[COUNT_BITS-1:0];
                CFG_IMAGE_WIDTH:  r_width    <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: r_height   <= i_cfg_data[SIZE_W-1:0];
                CFG_ZOOM:         r_zoom     <= i_cfg_data[ZOOM_W-1:0];
                CFG_SHIFT_REAL:   r_shift_re <= i_cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_IMAG:   r_shift_im <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_pix.ready           = (r_state == ST_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.out_column      = r_out_col;
    assign o_res.out_row         = r_out_row;
    assign o_res.iteration_count = r_out_cnt;
    assign o_res.escaped         = r_out_esc;

endmodule

/* rtl/jet_checker.sv */
// port-level checks of the julia escape-time pixel block, bound to the top level
// depends on jet_pkg and julia_escape_time_pixel
module jet_checker import jet_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COUNT_BITS-1:0] i_out_count,
    input logic                  i_out_escaped,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [COUNT_BITS-1:0] r_max_iter;

    // shadow of the iteration limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_we && i_cfg_index == CFG_MAX_ITER) begin
            r_max_iter <= i_cfg_data[COUNT_BITS-1:0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("pixel accepted while previous pixel in work");

    a_escape_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_escaped == (i_out_count < r_max_iter)))
        else $error("escaped flag disagrees with count and limit");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count <= r_max_iter))
        else $error("iteration count above limit");

endmodule

bind julia_escape_time_pixel jet_checker u_jet_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_count   (o_res.iteration_count),
    .i_out_escaped (o_res.escaped),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);
